// ===== sv/fms_pkg.sv =====
package fms_pkg;

    typedef enum logic [3:0] {
        ST_BOOT      = 4'd0,
        ST_SELFCHECK = 4'd1,
        ST_IDLE      = 4'd2,
        ST_PRIMED    = 4'd3,
        ST_TAKEOFF   = 4'd4,
        ST_STABILIZE = 4'd5,
        ST_HOLD_ALT  = 4'd6,
        ST_HOLD_POS  = 4'd7,
        ST_ROUTE     = 4'd8,
        ST_DESCENT   = 4'd9,
        ST_SAFE_STOP = 4'd10
    } state_t;

    typedef enum logic [2:0] {
        MODE_TAKEOFF   = 3'd0,
        MODE_STABILIZE = 3'd1,
        MODE_ALT_HOLD  = 3'd2,
        MODE_POS_HOLD  = 3'd3,
        MODE_LANDING   = 3'd4
    } mode_t;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_INIT_DONE = 4'd1;
    localparam logic [3:0] EV_TESTS_OK  = 4'd2;
    localparam logic [3:0] EV_ERR       = 4'd3;
    localparam logic [3:0] EV_ARM       = 4'd4;
    localparam logic [3:0] EV_TAKEOFF   = 4'd5;
    localparam logic [3:0] EV_LANDED    = 4'd6;
    localparam logic [3:0] EV_EXCEPT    = 4'd7;
    localparam logic [3:0] EV_ALT_HOLD  = 4'd8;
    localparam logic [3:0] EV_POS_HOLD  = 4'd9;
    localparam logic [3:0] EV_STABILIZE = 4'd10;
    localparam logic [3:0] EV_LAND      = 4'd11;
    localparam logic [3:0] EV_MISSION   = 4'd12;
    localparam logic [3:0] EV_ABORT     = 4'd13;
    localparam logic [3:0] EV_MISSION_DONE = 4'd14;

    localparam logic [1:0] CFG_TAKEOFF_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_ALT_TOLERANCE  = 2'd1;
    localparam logic [1:0] CFG_BATT_CRITICAL  = 2'd2;
    localparam logic [1:0] CFG_BATT_LOW       = 2'd3;

    localparam logic [15:0] TAKEOFF_HEIGHT_RST = 16'd100;
    localparam logic [15:0] ALT_TOLERANCE_RST  = 16'd10;
    localparam logic [13:0] BATT_CRITICAL_RST  = 14'd1000;
    localparam logic [13:0] BATT_LOW_RST       = 14'd2000;

    localparam logic signed [20:0] ALT_MAX = 21'sd524287;

    typedef struct packed {
        logic [15:0] takeoff_height_cm;
        logic [15:0] altitude_tolerance_cm;
        logic [13:0] battery_critical_level;
        logic [13:0] battery_low_level;
    } cfg_t;

    // s_tdata layout, lowest bits last
    typedef struct packed {
        logic [1:0]         pad;
        logic [13:0]        battery_level;
        logic signed [19:0] altitude_cm;
        logic [3:0]         event_code;
    } in_data_t;

    typedef struct packed {
        logic     event_valid;
        in_data_t data;
    } in_item_t;

    // m_tdata layout, lowest bits last
    typedef struct packed {
        logic               state_changed;
        logic signed [19:0] target_altitude;
        logic               battery_low;
        logic               warning_flag;
        logic               motors_on;
        logic               armed_flag;
        mode_t              flight_mode;
        state_t             flight_state;
    } out_item_t;

    typedef struct packed {
        state_t             state;
        mode_t              mode;
        logic               tests_ok;
        logic               armed;
        logic               motors;
        logic               warning;
        logic signed [19:0] target;
    } ctx_t;

    typedef struct packed {
        logic advance;
    } in_ctl_t;

    function automatic ctx_t fms_handle(input ctx_t s, input logic [3:0] ev,
                                        input logic signed [19:0] alt,
                                        input logic [13:0] batt, input cfg_t c);
        ctx_t               r;
        logic               fault;
        logic signed [20:0] sum;
        logic signed [20:0] diff;
        logic [20:0]        mag;
        logic               near;
        r     = s;
        fault = (ev == EV_ERR) || (ev == EV_EXCEPT);
        sum   = $signed({alt[19], alt}) + $signed({5'b0, c.takeoff_height_cm});
        diff  = $signed({alt[19], alt}) - $signed({s.target[19], s.target});
        mag   = diff[20] ? 21'(-diff) : 21'(diff);
        near  = mag < {5'b0, c.altitude_tolerance_cm};
        unique case (s.state)
            ST_BOOT:
            begin
                if (ev == EV_NONE || ev == EV_INIT_DONE) r.state = ST_SELFCHECK;
            end
            ST_SELFCHECK:
            begin
                if (ev == EV_TESTS_OK)
                begin
                    r.tests_ok = 1'b1;
                    r.state    = ST_IDLE;
                end
                if (ev == EV_ERR) r.state = ST_SAFE_STOP;
            end
            ST_IDLE:
            begin
                if (ev == EV_ARM && s.tests_ok && batt > c.battery_critical_level)
                begin
                    r.armed  = 1'b1;
                    r.motors = 1'b1;
                    r.state  = ST_PRIMED;
                end
                if (ev == EV_ERR) r.state = ST_SAFE_STOP;
            end
            ST_PRIMED:
            begin
                if (ev == EV_TAKEOFF)
                begin
                    r.target = (sum > ALT_MAX) ? ALT_MAX[19:0] : sum[19:0];
                    r.state  = ST_TAKEOFF;
                end
                if (ev == EV_ARM || ev == EV_ERR)
                begin
                    r.armed  = 1'b0;
                    r.motors = 1'b0;
                    r.state  = ST_IDLE;
                end
                if (ev == EV_ERR) r.state = ST_SAFE_STOP;
            end
            ST_TAKEOFF:
            begin
                if (near)
                begin
                    r.mode  = MODE_ALT_HOLD;
                    r.state = ST_HOLD_ALT;
                end
                if (ev == EV_LANDED)
                begin
                    r.armed  = 1'b0;
                    r.motors = 1'b0;
                    r.state  = ST_IDLE;
                end
                if (fault) r.state = ST_SAFE_STOP;
            end
            ST_STABILIZE, ST_HOLD_ALT, ST_HOLD_POS:
            begin
                if (ev == EV_STABILIZE && s.state != ST_STABILIZE)
                begin
                    r.mode  = MODE_STABILIZE;
                    r.state = ST_STABILIZE;
                end
                if (ev == EV_ALT_HOLD && s.state != ST_HOLD_ALT)
                begin
                    r.mode  = MODE_ALT_HOLD;
                    r.state = ST_HOLD_ALT;
                end
                if (ev == EV_POS_HOLD && s.state != ST_HOLD_POS)
                begin
                    r.mode  = MODE_POS_HOLD;
                    r.state = ST_HOLD_POS;
                end
                if (ev == EV_MISSION && s.state == ST_HOLD_POS) r.state = ST_ROUTE;
                if (ev == EV_LAND || fault || (ev == EV_ABORT && s.state == ST_HOLD_POS))
                begin
                    r.mode  = MODE_LANDING;
                    r.state = ST_DESCENT;
                end
            end
            ST_ROUTE:
            begin
                if (ev == EV_MISSION_DONE || ev == EV_ABORT || fault)
                begin
                    r.mode  = MODE_LANDING;
                    r.state = ST_DESCENT;
                end
            end
            ST_DESCENT:
            begin
                if (fault) r.mode = MODE_LANDING;
            end
            ST_SAFE_STOP:
            begin
                r.warning = 1'b1;
                r.motors  = 1'b0;
                if (ev == EV_INIT_DONE)
                begin
                    r.armed = 1'b0;
                    r.state = ST_IDLE;
                end
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== sv/fms_cfg_regs.sv =====
module fms_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output fms_pkg::cfg_t cfg
);
    import fms_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.takeoff_height_cm      <= TAKEOFF_HEIGHT_RST;
            cfg_reg.altitude_tolerance_cm  <= ALT_TOLERANCE_RST;
            cfg_reg.battery_critical_level <= BATT_CRITICAL_RST;
            cfg_reg.battery_low_level      <= BATT_LOW_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TAKEOFF_HEIGHT: cfg_reg.takeoff_height_cm      <= cfg_data;
                CFG_ALT_TOLERANCE:  cfg_reg.altitude_tolerance_cm  <= cfg_data;
                CFG_BATT_CRITICAL:  cfg_reg.battery_critical_level <= cfg_data[13:0];
                CFG_BATT_LOW:       cfg_reg.battery_low_level      <= cfg_data[13:0];
                default:            cfg_reg                        <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== sv/fms_in_reg.sv =====
module fms_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic              s_tuser,
    input  fms_pkg::in_ctl_t  ctl,
    output logic              item_valid,
    output fms_pkg::in_item_t item
);
    import fms_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;

    assign s_tready   = !vld_reg || ctl.advance;
    assign vld_next   = s_tvalid || (vld_reg && !ctl.advance);
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= {s_tuser, in_data_t'(s_tdata)};
        end
    end

endmodule

// ===== sv/fms_core.sv =====
module fms_core (
    input  logic              clk,
    input  logic              rst_n,
    input  fms_pkg::cfg_t     cfg,
    input  logic              item_valid,
    input  fms_pkg::in_item_t item,
    output fms_pkg::in_ctl_t  ctl,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata
);
    import fms_pkg::*;

    ctx_t      ctx_reg;
    ctx_t      ctx_mid;
    ctx_t      ctx_next;
    logic      out_vld_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic      critical;
    logic      advance;

    assign advance     = item_valid && (!out_vld_reg || m_tready);
    assign ctl.advance = advance;

    // battery abort first, then the beat's own event
    always_comb
    begin
        critical = (item.data.battery_level < cfg.battery_critical_level)
                && (ctx_reg.state >= ST_PRIMED) && (ctx_reg.state <= ST_ROUTE);
        ctx_mid  = critical ? fms_handle(ctx_reg, EV_EXCEPT, item.data.altitude_cm,
                                         item.data.battery_level, cfg) : ctx_reg;
        ctx_next = item.event_valid ? fms_handle(ctx_mid, item.data.event_code,
                                                 item.data.altitude_cm,
                                                 item.data.battery_level, cfg) : ctx_mid;
        out_next.flight_state    = ctx_next.state;
        out_next.flight_mode     = ctx_next.mode;
        out_next.armed_flag      = ctx_next.armed;
        out_next.motors_on       = ctx_next.motors;
        out_next.warning_flag    = ctx_next.warning;
        out_next.battery_low     = item.data.battery_level <= cfg.battery_low_level;
        out_next.target_altitude = ctx_next.target;
        out_next.state_changed   = ctx_next.state != ctx_reg.state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state    <= ST_BOOT;
            ctx_reg.mode     <= MODE_TAKEOFF;
            ctx_reg.tests_ok <= 1'b0;
            ctx_reg.armed    <= 1'b0;
            ctx_reg.motors   <= 1'b0;
            ctx_reg.warning  <= 1'b0;
            ctx_reg.target   <= '0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                ctx_reg <= ctx_next;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== sv/flight_mode_supervisor.sv =====
// channel   | dir | beat fields
// s_*       | in  | tuser: event_valid; tdata: event_code, altitude_cm, battery_level
// m_*       | out | tdata: flight_state .. state_changed
// cfg_*     | in  | cfg_index selects register, cfg_data is the value
//
// one beat per cycle sustained while m_tready stays high; a result is offered once its input
// beat has passed the input register and then the state update into the result register
// reset loads the register defaults and puts the supervisor in boot
// with m_tready low the result holds, one more beat waits in the input
// register, then s_tready drops
module flight_mode_supervisor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // event_code, altitude_cm, battery_level, 2 pad bits
    input  logic        s_tuser,   // event_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // flight_state, flight_mode, armed_flag, motors_on,
                                   // warning_flag, battery_low, target_altitude,
                                   // state_changed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fms_pkg::*;

    cfg_t     cfg;
    in_ctl_t  ctl;
    logic     item_valid;
    in_item_t item;

    fms_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fms_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .ctl        (ctl),
        .item_valid (item_valid),
        .item       (item)
    );

    fms_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .ctl        (ctl),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== sv/fms_checker.sv =====
module fms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import fms_pkg::*;

    out_item_t res;

    assign res = m_tdata;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_idle_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.flight_state == ST_IDLE |-> !res.armed_flag && !res.motors_on)
        else $error("idle with motors armed");

    a_motors_armed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.motors_on |-> res.armed_flag)
        else $error("motors on while disarmed");

    a_landing_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.flight_state == ST_DESCENT |-> res.flight_mode == MODE_LANDING)
        else $error("landing state without landing mode");

endmodule

bind flight_mode_supervisor fms_checker u_fms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
